>>> rtl/hsla_pkg.sv
// Shared types, constants and tables of the softmax log-likelihood accumulator.
`timescale 1ns / 1ps
`default_nettype none

package hsla_pkg;

  localparam int NUM_COEF   = 4;
  localparam int GROUP_BITS = 16;
  localparam int COEF_W     = (NUM_COEF > 1) ? $clog2(NUM_COEF) : 1;
  localparam int LN2_Q16    = 45426;
  localparam int EXP_TERMS  = 10;
  localparam int LOG_LAST   = 19;
  localparam int DIV_STEPS  = 30;
  localparam int K_STEPS    = 5;

  typedef struct packed {
    logic               first_item;
    logic [15:0]        group_id;
    logic signed [23:0] log_odds;
    logic signed [23:0] weight;
    logic signed [23:0] deriv_0;
    logic signed [23:0] deriv_1;
    logic signed [23:0] deriv_2;
    logic signed [23:0] deriv_3;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] log_likelihood;
    logic signed [39:0] grad_0;
    logic signed [39:0] grad_1;
    logic signed [39:0] grad_2;
    logic signed [39:0] grad_3;
    logic               weight_error;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECIDE,
    OP_EXP_LOAD,
    OP_EXP_ZERO,
    OP_EXP_K,
    OP_MUL_TERM,
    OP_MUL_RECIP,
    OP_EXP_ACC,
    OP_EXP_FIN,
    OP_LOG_LOAD,
    OP_LOG_DIV,
    OP_MUL_ZZ,
    OP_LOG_Z2,
    OP_MUL_PW,
    OP_LOG_ACC,
    OP_LOG_FIN,
    OP_MUL_MEAN,
    OP_MEAN_ADD,
    OP_MUL_LL,
    OP_LL_ADD,
    OP_MUL_GR,
    OP_GR_ADD,
    OP_FINISH
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EXP_LD,
    ST_EXP_K,
    ST_EXP_M1,
    ST_EXP_M2,
    ST_EXP_M3,
    ST_EXP_FIN,
    ST_LOG_LD,
    ST_LOG_DIV,
    ST_LOG_Z2,
    ST_LOG_Z2B,
    ST_LOG_M1,
    ST_LOG_M2,
    ST_LOG_M3,
    ST_LOG_FIN,
    ST_MEAN_M,
    ST_MEAN_A,
    ST_LL_M,
    ST_LL_A,
    ST_GR_M,
    ST_GR_A,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] idx;
    logic       src;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic cut;
  } status_t;

  // Reciprocals floor((2^32 - 1) / n) for the term divisors of both series.
  function automatic logic [31:0] recip(input logic [4:0] n);
    logic [31:0] m;
    begin
      case (n)
        5'd1:    m = 32'd4294967295;
        5'd2:    m = 32'd2147483647;
        5'd3:    m = 32'd1431655765;
        5'd4:    m = 32'd1073741823;
        5'd5:    m = 32'd858993459;
        5'd6:    m = 32'd715827882;
        5'd7:    m = 32'd613566756;
        5'd8:    m = 32'd536870911;
        5'd9:    m = 32'd477218588;
        5'd10:   m = 32'd429496729;
        5'd11:   m = 32'd390451572;
        5'd13:   m = 32'd330382099;
        5'd15:   m = 32'd286331153;
        5'd17:   m = 32'd252645135;
        5'd19:   m = 32'd226050910;
        default: m = 32'd4294967295;
      endcase
      recip = m;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/harville_softmax_loglik_accum.sv
// Top level of the weighted Plackett-Luce log-likelihood and gradient accumulator.
//
//   port group   direction  transaction / payload
//   in_*         input      valid/ready, hsla_pkg::in_item_t
//   out_*        output     valid/ready, hsla_pkg::out_item_t
//   cfg_*        input      write enable, gradient enable bit
//
// A transaction that seeds a group or carries a negative weight skips straight to the result.
// Any other transaction runs the divider and the log series, and each of the two exponentials
// ends early with a zero result at an argument of 16.0 or more, else runs its full series.
// Reset is synchronous and active low; it clears all totals and sets gradient enable.
// A finished result waits in the output register while the next transaction is taken.
`timescale 1ns / 1ps
`default_nettype none

module harville_softmax_loglik_accum (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  hsla_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hsla_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata
);
  import hsla_pkg::*;

  cmd_t    cmd;
  status_t status;

  hsla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hsla_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // The block takes one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // Loading the output register always presents a result.
  a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FINISH |=> out_valid)
    else $error("result loaded without valid");

  // While waiting for input the datapath only captures the payload.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cmd.op == OP_NONE || cmd.op == OP_LOAD))
    else $error("datapath busy while ready for input");
`endif

endmodule

`default_nettype wire

>>> rtl/hsla_dp.sv
// Datapath: operand registers, shared multiplier, series and division steps, totals.
`timescale 1ns / 1ps
`default_nettype none

module hsla_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  hsla_pkg::in_item_t   in_data,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata,
  input  hsla_pkg::cmd_t       cmd,
  output hsla_pkg::status_t    status,
  output hsla_pkg::out_item_t  out_data
);
  import hsla_pkg::*;

  in_item_t                item_r;
  logic [GROUP_BITS-1:0]   last_group_r;
  logic signed [31:0]      log_sum_r;
  logic signed [31:0]      mean_r [NUM_COEF];
  logic signed [39:0]      ll_r;
  logic signed [39:0]      grad_r [NUM_COEF];
  logic                    gen_r;

  logic signed [31:0]      mx_r;
  logic [33:0]             dd_r;
  logic [19:0]             rr_r;
  logic [4:0]              k_r;
  logic                    cut_r;
  logic [30:0]             term_r;
  logic [31:0]             spos_r;
  logic [31:0]             sneg_r;
  logic [16:0]             expv_r;
  logic [17:0]             drem_r;
  logic [29:0]             z_r;
  logic [29:0]             z2_r;
  logic [29:0]             pw_r;
  logic [29:0]             qt_r;
  logic [31:0]             lsum_r;
  logic signed [31:0]      lse_r;
  logic signed [33:0]      t_r;
  logic signed [67:0]      prod_r;
  out_item_t               out_r;

  logic signed [23:0]      d_w [NUM_COEF];
  logic [COEF_W-1:0]       ci;
  logic signed [33:0]      eta_ext;
  logic signed [33:0]      diff;
  logic                    eta_gt;
  logic                    seed;
  logic                    err;
  logic [33:0]             arg;
  logic [20:0]             ln2s;
  logic [29:0]             r30;
  logic signed [33:0]      mul_a;
  logic signed [33:0]      mul_b;
  logic signed [67:0]      mul_p;
  logic [29:0]             approx;
  logic [34:0]             an;
  logic [34:0]             qrem;
  logic [29:0]             qfix;
  logic [31:0]             esum;
  logic [5:0]              esh;
  logic [39:0]             ebig;
  logic [17:0]             dvs;
  logic [18:0]             rem2;
  logic [16:0]             l1p;
  logic signed [33:0]      lse_full;
  logic signed [31:0]      lse_sat;
  logic signed [33:0]      tval;
  logic signed [32:0]      dmm;
  logic signed [67:0]      rnd;
  logic signed [41:0]      llsum;
  logic signed [41:0]      grsum;

  function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
    logic signed [39:0] r;
    begin
      if (v[41:39] == 3'b000 || v[41:39] == 3'b111) begin
        r = v[39:0];
      end else if (v[41]) begin
        r = {1'b1, 39'd0};
      end else begin
        r = {1'b0, {39{1'b1}}};
      end
      sat40 = r;
    end
  endfunction

  assign d_w[0] = item_r.deriv_0;
  assign d_w[1] = item_r.deriv_1;
  assign d_w[2] = item_r.deriv_2;
  assign d_w[3] = item_r.deriv_3;

  assign ci      = cmd.idx[COEF_W-1:0];
  assign eta_ext = 34'(item_r.log_odds);
  assign diff    = eta_ext - 34'(log_sum_r);
  assign eta_gt  = eta_ext > 34'(log_sum_r);
  assign seed    = item_r.first_item || (item_r.group_id[GROUP_BITS-1:0] != last_group_r);
  assign err     = item_r.weight[23];

  assign status.skip = err || seed;
  assign status.cut  = cut_r;

  assign arg  = cmd.src ? 34'(-t_r) : dd_r;
  assign ln2s = 21'(LN2_Q16) << cmd.idx[2:0];
  assign r30  = {rr_r[15:0], 14'd0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_TERM: begin
        mul_a = 34'(term_r);
        mul_b = 34'(r30);
      end
      OP_MUL_RECIP: begin
        mul_a = 34'(prod_r[59:30]);
        mul_b = 34'(recip(cmd.idx));
      end
      OP_MUL_ZZ: begin
        mul_a = 34'(z_r);
        mul_b = 34'(z_r);
      end
      OP_MUL_PW: begin
        mul_a = 34'(pw_r);
        mul_b = 34'(z2_r);
      end
      OP_MUL_MEAN: begin
        mul_a = 34'(expv_r);
        mul_b = 34'(dmm);
      end
      OP_MUL_LL: begin
        mul_a = 34'(item_r.weight);
        mul_b = t_r;
      end
      OP_MUL_GR: begin
        mul_a = 34'(item_r.weight);
        mul_b = 34'(dmm);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Reciprocal quotient is exact or one low; a single correction fixes it.
  assign approx = prod_r[61:32];
  assign an     = 35'(approx) * 35'(cmd.idx);
  assign qrem   = 35'(qt_r) - an;
  assign qfix   = (qrem >= 35'(cmd.idx)) ? approx + 30'd1 : approx;

  assign esum = spos_r - sneg_r;
  assign esh  = 6'd14 + 6'(k_r);
  assign ebig = 40'(esum) + (40'd1 << (esh - 6'd1));

  assign dvs  = {1'b1, expv_r};
  assign rem2 = {drem_r, 1'b0};

  assign l1p      = 17'((({lsum_r, 1'b0}) + 33'd8192) >> 14);
  assign lse_full = 34'(mx_r) + $signed({17'd0, l1p});
  always_comb begin
    if (lse_full[33:31] == 3'b000 || lse_full[33:31] == 3'b111) begin
      lse_sat = lse_full[31:0];
    end else if (lse_full[33]) begin
      lse_sat = {1'b1, 31'd0};
    end else begin
      lse_sat = {1'b0, {31{1'b1}}};
    end
  end
  assign tval = eta_ext - 34'(lse_sat);

  assign dmm   = 33'(d_w[ci]) - 33'(mean_r[ci]);
  assign rnd   = (prod_r + 68'sd32768) >>> 16;
  assign llsum = 42'(ll_r) + $signed(rnd[41:0]);
  assign grsum = 42'(grad_r[ci]) + $signed(rnd[41:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_group_r <= '0;
      log_sum_r    <= '0;
      ll_r         <= '0;
      gen_r        <= 1'b1;
      for (int c = 0; c < NUM_COEF; c++) begin
        mean_r[c] <= '0;
        grad_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        gen_r <= cfg_wdata;
      end
      case (cmd.op)
        OP_DECIDE: begin
          if (!err && seed) begin
            if (item_r.first_item) begin
              ll_r <= '0;
              for (int c = 0; c < NUM_COEF; c++) begin
                grad_r[c] <= '0;
              end
            end
            last_group_r <= item_r.group_id[GROUP_BITS-1:0];
            log_sum_r    <= 32'(item_r.log_odds);
            for (int c = 0; c < NUM_COEF; c++) begin
              mean_r[c] <= 32'(d_w[c]);
            end
          end
        end
        OP_MEAN_ADD: mean_r[ci] <= mean_r[ci] + rnd[31:0];
        OP_LL_ADD: begin
          ll_r      <= sat40(llsum);
          log_sum_r <= lse_r;
        end
        OP_GR_ADD: grad_r[ci] <= sat40(grsum);
        OP_FINISH: begin
          if (!gen_r) begin
            for (int c = 0; c < NUM_COEF; c++) begin
              grad_r[c] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: item_r <= in_data;
      OP_DECIDE: begin
        mx_r <= eta_gt ? 32'(item_r.log_odds) : log_sum_r;
        dd_r <= eta_gt ? diff : -diff;
      end
      OP_EXP_LOAD: begin
        cut_r  <= |arg[33:20];
        rr_r   <= arg[19:0];
        k_r    <= '0;
        term_r <= 31'd1 << 30;
        spos_r <= 32'd1 << 30;
        sneg_r <= '0;
      end
      OP_EXP_ZERO: expv_r <= '0;
      OP_EXP_K: begin
        if ({1'b0, rr_r} >= ln2s) begin
          rr_r <= rr_r - ln2s[19:0];
          k_r  <= k_r | (5'd1 << cmd.idx[2:0]);
        end
      end
      OP_MUL_TERM, OP_MUL_ZZ, OP_MUL_PW, OP_MUL_MEAN, OP_MUL_LL, OP_MUL_GR: begin
        prod_r <= mul_p;
      end
      OP_MUL_RECIP: begin
        prod_r <= mul_p;
        qt_r   <= prod_r[59:30];
        pw_r   <= prod_r[59:30];
      end
      OP_EXP_ACC: begin
        term_r <= 31'(qfix);
        if (cmd.idx[0]) begin
          sneg_r <= sneg_r + 32'(qfix);
        end else begin
          spos_r <= spos_r + 32'(qfix);
        end
      end
      OP_EXP_FIN: expv_r <= 17'(ebig >> esh);
      OP_LOG_LOAD: begin
        drem_r <= {1'b0, expv_r};
        z_r    <= '0;
      end
      OP_LOG_DIV: begin
        if (rem2 >= {1'b0, dvs}) begin
          drem_r <= 18'(rem2 - {1'b0, dvs});
          z_r    <= {z_r[28:0], 1'b1};
        end else begin
          drem_r <= rem2[17:0];
          z_r    <= {z_r[28:0], 1'b0};
        end
      end
      OP_LOG_Z2: begin
        z2_r   <= prod_r[59:30];
        pw_r   <= z_r;
        lsum_r <= 32'(z_r);
      end
      OP_LOG_ACC: lsum_r <= lsum_r + 32'(qfix);
      OP_LOG_FIN: begin
        lse_r <= lse_sat;
        t_r   <= tval[33] ? tval : '0;
      end
      OP_FINISH: begin
        out_r.log_likelihood <= ll_r;
        out_r.grad_0         <= gen_r ? grad_r[0] : '0;
        out_r.grad_1         <= gen_r ? grad_r[1] : '0;
        out_r.grad_2         <= gen_r ? grad_r[2] : '0;
        out_r.grad_3         <= gen_r ? grad_r[3] : '0;
        out_r.weight_error   <= err;
      end
      default: begin
      end
    endcase
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> rtl/hsla_ctrl.sv
// Controller: sequences the datapath steps of one transaction and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module hsla_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  hsla_pkg::status_t  status,
  output hsla_pkg::cmd_t     cmd
);
  import hsla_pkg::*;

  state_e     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  state_e     exp_ret;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign exp_ret   = phase_r ? ST_MEAN_M : ST_LOG_LD;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.idx       = cnt_r;
    cmd.src       = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.op = OP_DECIDE;
        if (status.skip) begin
          state_nxt = ST_DONE;
        end else begin
          phase_nxt = 1'b0;
          state_nxt = ST_EXP_LD;
        end
      end
      ST_EXP_LD: begin
        cmd.op    = OP_EXP_LOAD;
        cnt_nxt   = 5'(K_STEPS - 1);
        state_nxt = ST_EXP_K;
      end
      ST_EXP_K: begin
        if (status.cut) begin
          cmd.op    = OP_EXP_ZERO;
          cnt_nxt   = '0;
          state_nxt = exp_ret;
        end else begin
          cmd.op = OP_EXP_K;
          if (cnt_r == '0) begin
            cnt_nxt   = 5'd1;
            state_nxt = ST_EXP_M1;
          end else begin
            cnt_nxt = cnt_r - 5'd1;
          end
        end
      end
      ST_EXP_M1: begin
        cmd.op    = OP_MUL_TERM;
        state_nxt = ST_EXP_M2;
      end
      ST_EXP_M2: begin
        cmd.op    = OP_MUL_RECIP;
        state_nxt = ST_EXP_M3;
      end
      ST_EXP_M3: begin
        cmd.op = OP_EXP_ACC;
        if (cnt_r == 5'(EXP_TERMS)) begin
          state_nxt = ST_EXP_FIN;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = ST_EXP_M1;
        end
      end
      ST_EXP_FIN: begin
        cmd.op    = OP_EXP_FIN;
        cnt_nxt   = '0;
        state_nxt = exp_ret;
      end
      ST_LOG_LD: begin
        cmd.op    = OP_LOG_LOAD;
        cnt_nxt   = '0;
        state_nxt = ST_LOG_DIV;
      end
      ST_LOG_DIV: begin
        cmd.op = OP_LOG_DIV;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = ST_LOG_Z2;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_LOG_Z2: begin
        cmd.op    = OP_MUL_ZZ;
        state_nxt = ST_LOG_Z2B;
      end
      ST_LOG_Z2B: begin
        cmd.op    = OP_LOG_Z2;
        cnt_nxt   = 5'd3;
        state_nxt = ST_LOG_M1;
      end
      ST_LOG_M1: begin
        cmd.op    = OP_MUL_PW;
        state_nxt = ST_LOG_M2;
      end
      ST_LOG_M2: begin
        cmd.op    = OP_MUL_RECIP;
        state_nxt = ST_LOG_M3;
      end
      ST_LOG_M3: begin
        cmd.op = OP_LOG_ACC;
        if (cnt_r == 5'(LOG_LAST)) begin
          state_nxt = ST_LOG_FIN;
        end else begin
          cnt_nxt   = cnt_r + 5'd2;
          state_nxt = ST_LOG_M1;
        end
      end
      ST_LOG_FIN: begin
        cmd.op    = OP_LOG_FIN;
        phase_nxt = 1'b1;
        state_nxt = ST_EXP_LD;
      end
      ST_MEAN_M: begin
        cmd.op    = OP_MUL_MEAN;
        state_nxt = ST_MEAN_A;
      end
      ST_MEAN_A: begin
        cmd.op = OP_MEAN_ADD;
        if (cnt_r == 5'(NUM_COEF - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_LL_M;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = ST_MEAN_M;
        end
      end
      ST_LL_M: begin
        cmd.op    = OP_MUL_LL;
        state_nxt = ST_LL_A;
      end
      ST_LL_A: begin
        cmd.op    = OP_LL_ADD;
        cnt_nxt   = '0;
        state_nxt = ST_GR_M;
      end
      ST_GR_M: begin
        cmd.op    = OP_MUL_GR;
        state_nxt = ST_GR_A;
      end
      ST_GR_A: begin
        cmd.op = OP_GR_ADD;
        if (cnt_r == 5'(NUM_COEF - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = ST_GR_M;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
